@@ design/hrlp_pkg.sv @@
// ============================================================================
// hrlp_pkg - shared types and constants for the HTTP request line parser
// Holds the phase and status codes, the parser state and result words, and
// the character tables used to match the method and the version text.
// ============================================================================
package hrlp_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_DONE    = 2'd0,
        PH_METHOD  = 2'd1,
        PH_PATH    = 2'd2,
        PH_VERSION = 2'd3
    } phase_t;

    // Verdict status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_METHOD  = 2'd1,
        ST_BAD_PATH    = 2'd2,
        ST_BAD_VERSION = 2'd3
    } status_t;

    // Result kinds
    localparam logic KIND_PATH    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Method and version codes
    localparam logic METHOD_GET  = 1'b0;
    localparam logic METHOD_POST = 1'b1;
    localparam logic VER_1_1     = 1'b0;
    localparam logic VER_1_0     = 1'b1;

    // Configuration register indexes
    localparam logic CFG_POST_ENABLED       = 1'b0;
    localparam logic CFG_PATH_CHECK_ENABLED = 1'b1;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;

    // Lengths of the matched texts ("GET ", "POST ", "HTTP/1.")
    localparam logic [2:0] GET_LEN  = 3'd4;
    localparam logic [2:0] POST_LEN = 3'd5;
    localparam logic [2:0] VER_LEN  = 3'd7;

    // Parser state word
    typedef struct packed {
        phase_t     phase;
        logic [2:0] pos;
        logic       method_seen;
        logic       path_started;
    } state_t;

    // Result word
    typedef struct packed {
        logic       kind;
        logic [7:0] path_byte;
        logic       method;
        logic       version;
        status_t    status;
        logic       last;
    } result_t;

    // Expected byte of "GET " at a position
    function automatic logic [7:0] get_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected byte of "POST " at a position
    function automatic logic [7:0] post_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h53;
            3'd3:    c = 8'h54;
            3'd4:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected byte of "HTTP/1." at a position
    function automatic logic [7:0] ver_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ design/hrlp_decode.sv @@
// ============================================================================
// hrlp_decode - per-byte parser step
// Combinational next state and result for one byte, given the current
// parser state and the configuration bits.
// ============================================================================
module hrlp_decode (
    input  logic             [7:0] data_byte,
    input  logic                   first,
    input  logic                   post_enabled,
    input  logic                   path_check_enabled,
    input  hrlp_pkg::state_t       cur,
    output hrlp_pkg::state_t       nxt,
    output logic                   res_valid,
    output hrlp_pkg::result_t      res
);

    hrlp_pkg::state_t eff;
    logic [2:0]       meth_len;
    logic [7:0]       meth_want;

    // Restart on the first byte of a line
    always_comb
    begin
        eff = cur;
        if (first)
        begin
            eff.phase        = hrlp_pkg::PH_METHOD;
            eff.pos          = 3'd0;
            eff.method_seen  = hrlp_pkg::METHOD_GET;
            eff.path_started = 1'b0;
        end
    end

    assign meth_len  = eff.method_seen ? hrlp_pkg::POST_LEN : hrlp_pkg::GET_LEN;
    assign meth_want = eff.method_seen ? hrlp_pkg::post_char(eff.pos)
                                       : hrlp_pkg::get_char(eff.pos);

    // Next state
    always_comb
    begin
        nxt = eff;
        unique case (eff.phase)
            hrlp_pkg::PH_METHOD:
            begin
                if (eff.pos == 3'd0)
                begin
                    if (data_byte == hrlp_pkg::CH_G)
                    begin
                        nxt.method_seen = hrlp_pkg::METHOD_GET;
                        nxt.pos         = 3'd1;
                    end
                    else if (data_byte == hrlp_pkg::CH_P && post_enabled)
                    begin
                        nxt.method_seen = hrlp_pkg::METHOD_POST;
                        nxt.pos         = 3'd1;
                    end
                    else
                    begin
                        nxt.phase = hrlp_pkg::PH_DONE;
                        nxt.pos   = 3'd0;
                    end
                end
                else if (eff.pos >= meth_len || data_byte != meth_want)
                begin
                    nxt.phase = hrlp_pkg::PH_DONE;
                    nxt.pos   = 3'd0;
                end
                else if (eff.pos + 3'd1 == meth_len)
                begin
                    nxt.phase = hrlp_pkg::PH_PATH;
                    nxt.pos   = 3'd0;
                end
                else
                begin
                    nxt.pos = eff.pos + 3'd1;
                end
            end
            hrlp_pkg::PH_PATH:
            begin
                if (data_byte == hrlp_pkg::CH_SPACE)
                begin
                    nxt.phase = (path_check_enabled && !eff.path_started)
                                ? hrlp_pkg::PH_DONE : hrlp_pkg::PH_VERSION;
                    nxt.pos   = 3'd0;
                end
                else if (path_check_enabled && !eff.path_started
                         && data_byte != hrlp_pkg::CH_SLASH)
                begin
                    nxt.phase = hrlp_pkg::PH_DONE;
                    nxt.pos   = 3'd0;
                end
                else
                begin
                    nxt.path_started = 1'b1;
                end
            end
            hrlp_pkg::PH_VERSION:
            begin
                if (eff.pos < hrlp_pkg::VER_LEN
                    && data_byte == hrlp_pkg::ver_char(eff.pos))
                begin
                    nxt.pos = eff.pos + 3'd1;
                end
                else
                begin
                    nxt.phase = hrlp_pkg::PH_DONE;
                    nxt.pos   = 3'd0;
                end
            end
            hrlp_pkg::PH_DONE:
            begin
                nxt = eff;
            end
        endcase
    end

    // Result
    always_comb
    begin
        res_valid     = 1'b0;
        res.kind      = hrlp_pkg::KIND_VERDICT;
        res.path_byte = 8'h00;
        res.method    = eff.method_seen;
        res.version   = hrlp_pkg::VER_1_1;
        res.status    = hrlp_pkg::ST_OK;
        res.last      = 1'b1;
        unique case (eff.phase)
            hrlp_pkg::PH_METHOD:
            begin
                if (eff.pos == 3'd0)
                begin
                    if (!(data_byte == hrlp_pkg::CH_G
                          || (data_byte == hrlp_pkg::CH_P && post_enabled)))
                    begin
                        res_valid  = 1'b1;
                        res.status = hrlp_pkg::ST_BAD_METHOD;
                    end
                end
                else if (eff.pos >= meth_len || data_byte != meth_want)
                begin
                    res_valid  = 1'b1;
                    res.status = hrlp_pkg::ST_BAD_METHOD;
                end
            end
            hrlp_pkg::PH_PATH:
            begin
                if (data_byte == hrlp_pkg::CH_SPACE)
                begin
                    if (path_check_enabled && !eff.path_started)
                    begin
                        res_valid  = 1'b1;
                        res.status = hrlp_pkg::ST_BAD_PATH;
                    end
                end
                else if (path_check_enabled && !eff.path_started
                         && data_byte != hrlp_pkg::CH_SLASH)
                begin
                    res_valid  = 1'b1;
                    res.status = hrlp_pkg::ST_BAD_PATH;
                end
                else
                begin
                    // Pass the path byte through
                    res_valid     = 1'b1;
                    res.kind      = hrlp_pkg::KIND_PATH;
                    res.path_byte = data_byte;
                    res.method    = hrlp_pkg::METHOD_GET;
                    res.last      = 1'b0;
                end
            end
            hrlp_pkg::PH_VERSION:
            begin
                if (eff.pos < hrlp_pkg::VER_LEN)
                begin
                    if (data_byte != hrlp_pkg::ver_char(eff.pos))
                    begin
                        res_valid  = 1'b1;
                        res.status = hrlp_pkg::ST_BAD_VERSION;
                    end
                end
                else
                begin
                    res_valid = 1'b1;
                    if (data_byte == hrlp_pkg::CH_ONE)
                        res.version = hrlp_pkg::VER_1_1;
                    else if (data_byte == hrlp_pkg::CH_ZERO)
                        res.version = hrlp_pkg::VER_1_0;
                    else
                        res.status = hrlp_pkg::ST_BAD_VERSION;
                end
            end
            hrlp_pkg::PH_DONE:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

endmodule

@@ design/hrlp_out_reg.sv @@
// ============================================================================
// hrlp_out_reg - result register
// Holds one result word for the master side and refills in the same cycle
// that the held word is taken.
// ============================================================================
module hrlp_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    output logic               ready,
    input  hrlp_pkg::result_t  res,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic        [15:0] m_axis_tdata,  // path_byte[7:0], method, version, status[1:0]
    output logic               m_axis_tuser,  // kind
    output logic               m_axis_tlast   // last
);

    logic              valid_reg;
    logic              valid_next;
    hrlp_pkg::result_t data_reg;

    // Free when empty or when the held word leaves this cycle
    assign ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'b0000, data_reg.status, data_reg.version,
                            data_reg.method, data_reg.path_byte};
    assign m_axis_tuser  = data_reg.kind;
    assign m_axis_tlast  = data_reg.last;

endmodule

@@ design/http_request_line_parser.sv @@
// ============================================================================
// http_request_line_parser - streaming HTTP/1.x request line parser
// Matches the method, passes path bytes through and gives one verdict per
// request line.
// ============================================================================
// Usage:
//   Slave side: one byte per word in s_axis_tdata[7:0]; s_axis_tuser set on
//   the first byte of a request line restarts the parser at that byte.
//   Master side: zero or one word per input byte. s_axis_tuser-style kind on
//   m_axis_tuser (0 path byte, 1 verdict); m_axis_tdata carries path_byte,
//   method, version and status; m_axis_tlast marks the verdict.
//   Bytes after a verdict give nothing until the next first-byte flag.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 POST
//   enable, 1 path check enable) at the clock edge; write only while idle.
// Timing:
//   A byte passes an input register and one step of the parser FSM into the
//   result register, from which its result word is offered on the master
//   side. One byte per cycle is sustained while the master side takes every
//   result word; the FSM step is one compare per byte against a small
//   character table.
//   When the master side stalls, the result register holds its word and the
//   input register holds the next byte; s_axis_tready drops only when both
//   are full.
//   Reset clears both registers, puts the parser in the done phase and sets
//   both configuration bits.
// ============================================================================
module http_request_line_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic  [7:0] s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // path_byte[7:0], method, version, status[1:0]
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic        cfg_wdata
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_first_reg;
    logic              post_enabled_reg;
    logic              path_check_enabled_reg;
    hrlp_pkg::state_t  state_reg;
    hrlp_pkg::state_t  state_next;
    logic              res_valid;
    hrlp_pkg::result_t res;
    logic              out_ready;
    logic              advance;
    logic              s_accept;

    // Step the held byte when its result, if any, has room
    assign advance       = in_valid_reg && (!res_valid || out_ready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_enabled_reg       <= 1'b1;
            path_check_enabled_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                hrlp_pkg::CFG_POST_ENABLED:       post_enabled_reg       <= cfg_wdata;
                hrlp_pkg::CFG_PATH_CHECK_ENABLED: path_check_enabled_reg <= cfg_wdata;
                default:                          post_enabled_reg       <= post_enabled_reg;
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= hrlp_pkg::PH_DONE;
            state_reg.pos          <= 3'd0;
            state_reg.method_seen  <= hrlp_pkg::METHOD_GET;
            state_reg.path_started <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    hrlp_decode u_decode (
        .data_byte          (in_byte_reg),
        .first              (in_first_reg),
        .post_enabled       (post_enabled_reg),
        .path_check_enabled (path_check_enabled_reg),
        .cur                (state_reg),
        .nxt                (state_next),
        .res_valid          (res_valid),
        .res                (res)
    );

    hrlp_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && res_valid),
        .ready         (out_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // A verdict leaves the parser in the done phase
    a_verdict_done: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res.kind == hrlp_pkg::KIND_VERDICT
        |=> state_reg.phase == hrlp_pkg::PH_DONE)
        else $error("parser not done after verdict");

    // Input stalls only while a byte is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // Path bytes carry ok status and no last mark
    a_path_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == hrlp_pkg::KIND_PATH
        |-> m_axis_tdata[11:10] == hrlp_pkg::ST_OK && !m_axis_tlast)
        else $error("path word with status or last set");

    // Version is only reported on an ok verdict
    a_version_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11:10] != hrlp_pkg::ST_OK
        |-> m_axis_tdata[9] == hrlp_pkg::VER_1_1)
        else $error("version set on failed verdict");
`endif

endmodule

@@ verif/http_request_line_parser_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// http_request_line_parser_tb - self-checking bench for the request parser
// Streams request lines byte by byte into the parser, predicts every path word
// and verdict in a scoreboard, and compares each result word field by field.
// Runs several register settings and flow-control patterns.
// ============================================================================
module http_request_line_parser_tb;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int PHASE_BYTES     = 230;
    localparam int NUM_PHASES      = 8;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parser state and holds the words still due
    // ------------------------------------------------------------------------
    class request_line_scoreboard;
        hrlp_pkg::phase_t  parse_phase;
        int unsigned       match_pos;
        logic              method_cur;
        logic              path_begun;
        logic              post_en;
        logic              check_en;
        hrlp_pkg::result_t due_words[$];
        string             get_txt  = "GET ";
        string             post_txt = "POST ";
        string             ver_txt  = "HTTP/1.";
        int                errors;
        int                path_words;
        int                verdicts[4];

        function new();
            parse_phase = hrlp_pkg::PH_DONE;
            match_pos   = 0;
            method_cur  = hrlp_pkg::METHOD_GET;
            path_begun  = 1'b0;
            post_en     = 1'b1;
            check_en    = 1'b1;
            errors      = 0;
            path_words  = 0;
            foreach (verdicts[i]) verdicts[i] = 0;
        endfunction

        function void set_reg(logic addr, logic val);
            if (addr == hrlp_pkg::CFG_POST_ENABLED)
                post_en = val;
            else
                check_en = val;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        // Queue a verdict and stop parsing until the next first byte
        function void push_verdict(logic ver, hrlp_pkg::status_t st);
            hrlp_pkg::result_t r;
            r.kind      = hrlp_pkg::KIND_VERDICT;
            r.path_byte = 8'h00;
            r.method    = method_cur;
            r.version   = ver;
            r.status    = st;
            r.last      = 1'b1;
            due_words.push_back(r);
            parse_phase = hrlp_pkg::PH_DONE;
            match_pos   = 0;
        endfunction

        // Advance the parser by one accepted byte
        function void take_byte(logic [7:0] b, logic first_flag);
            hrlp_pkg::result_t r;
            logic [7:0]        want;
            int unsigned       len;
            if (first_flag)
            begin
                parse_phase = hrlp_pkg::PH_METHOD;
                match_pos   = 0;
                method_cur  = hrlp_pkg::METHOD_GET;
                path_begun  = 1'b0;
            end
            case (parse_phase)
                hrlp_pkg::PH_METHOD:
                begin
                    if (match_pos == 0)
                    begin
                        if (b == hrlp_pkg::CH_G)
                        begin
                            method_cur = hrlp_pkg::METHOD_GET;
                            match_pos  = 1;
                        end
                        else if (b == hrlp_pkg::CH_P && post_en)
                        begin
                            method_cur = hrlp_pkg::METHOD_POST;
                            match_pos  = 1;
                        end
                        else
                            push_verdict(hrlp_pkg::VER_1_1, hrlp_pkg::ST_BAD_METHOD);
                    end
                    else
                    begin
                        len  = (method_cur == hrlp_pkg::METHOD_POST) ? post_txt.len()
                                                                     : get_txt.len();
                        want = (method_cur == hrlp_pkg::METHOD_POST) ? post_txt[match_pos]
                                                                     : get_txt[match_pos];
                        if (match_pos >= len || b != want)
                            push_verdict(hrlp_pkg::VER_1_1, hrlp_pkg::ST_BAD_METHOD);
                        else
                        begin
                            match_pos++;
                            if (match_pos == len)
                            begin
                                parse_phase = hrlp_pkg::PH_PATH;
                                match_pos   = 0;
                            end
                        end
                    end
                end
                hrlp_pkg::PH_PATH:
                begin
                    if (b == hrlp_pkg::CH_SPACE)
                    begin
                        if (check_en && !path_begun)
                            push_verdict(hrlp_pkg::VER_1_1, hrlp_pkg::ST_BAD_PATH);
                        else
                        begin
                            parse_phase = hrlp_pkg::PH_VERSION;
                            match_pos   = 0;
                        end
                    end
                    else if (check_en && !path_begun && b != hrlp_pkg::CH_SLASH)
                        push_verdict(hrlp_pkg::VER_1_1, hrlp_pkg::ST_BAD_PATH);
                    else
                    begin
                        path_begun  = 1'b1;
                        r.kind      = hrlp_pkg::KIND_PATH;
                        r.path_byte = b;
                        r.method    = hrlp_pkg::METHOD_GET;
                        r.version   = hrlp_pkg::VER_1_1;
                        r.status    = hrlp_pkg::ST_OK;
                        r.last      = 1'b0;
                        due_words.push_back(r);
                    end
                end
                hrlp_pkg::PH_VERSION:
                begin
                    if (match_pos < ver_txt.len())
                    begin
                        want = ver_txt[match_pos];
                        if (b != want)
                            push_verdict(hrlp_pkg::VER_1_1, hrlp_pkg::ST_BAD_VERSION);
                        else
                            match_pos++;
                    end
                    else if (b == hrlp_pkg::CH_ONE)
                        push_verdict(hrlp_pkg::VER_1_1, hrlp_pkg::ST_OK);
                    else if (b == hrlp_pkg::CH_ZERO)
                        push_verdict(hrlp_pkg::VER_1_0, hrlp_pkg::ST_OK);
                    else
                        push_verdict(hrlp_pkg::VER_1_1, hrlp_pkg::ST_BAD_VERSION);
                end
                default: ;
            endcase
        endfunction

        function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one output word against the oldest expectation
        function void check_word(logic [15:0] data, logic kind, logic last);
            hrlp_pkg::result_t e;
            if (due_words.size() == 0)
            begin
                $error("unexpected word: tdata 0x%04h tuser %0b tlast %0b", data, kind, last);
                errors++;
                return;
            end
            e = due_words.pop_front();
            cmp_field("kind", e.kind, kind);
            cmp_field("path_byte", e.path_byte, data[7:0]);
            cmp_field("method", e.method, data[8]);
            cmp_field("version", e.version, data[9]);
            cmp_field("status", e.status, data[11:10]);
            cmp_field("tdata padding", 0, data[15:12]);
            cmp_field("last", e.last, last);
            if (e.kind == hrlp_pkg::KIND_PATH)
                path_words++;
            else
                verdicts[e.status]++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic  [7:0] s_axis_tdata  = 8'h00;   // data_byte[7:0]
    logic        s_axis_tuser  = 1'b0;    // first
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // path_byte[7:0], method, version, status[1:0]
    logic        m_axis_tuser;            // kind
    logic        m_axis_tlast;            // last
    logic        cfg_we        = 1'b0;
    logic        cfg_addr      = 1'b0;
    logic        cfg_wdata     = 1'b0;

    request_line_scoreboard sb = new();

    int src_idle   = 0;
    int snk_stall  = 0;
    int quiet_cnt  = 0;
    int bytes_sent = 0;

    http_request_line_parser DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Randomly stall the result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= snk_stall);
    end

    // Watch both handshakes: note accepted bytes first, then check words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cnt <= 0;
            else
                quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= WATCHDOG_CYCLES)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d still due",
                         WATCHDOG_CYCLES, sb.pending());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------

    // Offer one byte, idling first at random; hold valid until taken
    task automatic send_byte(input logic [7:0] b, input logic first_flag);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first_flag;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic first_on_first);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], first_on_first && (i == 0));
    endtask

    // Stop sending, let the monitor note the last byte, wait for every due
    // word, then let in-flight bytes settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_config(input logic post_val, input logic check_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= hrlp_pkg::CFG_POST_ENABLED;
        cfg_wdata <= post_val;
        @(posedge clk);
        cfg_addr  <= hrlp_pkg::CFG_PATH_CHECK_ENABLED;
        cfg_wdata <= check_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(hrlp_pkg::CFG_POST_ENABLED, post_val);
        sb.set_reg(hrlp_pkg::CFG_PATH_CHECK_ENABLED, check_val);
    endtask

    // Build one request line with random content, sometimes broken or cut short
    task automatic send_request();
        logic [7:0] line[$];
        string      mtxt;
        string      vtxt;
        int         plen;
        int         cut;
        int         sel;
        logic       use_post;
        vtxt     = "HTTP/1.";
        use_post = sb.post_en ? 1'($urandom_range(1)) : ($urandom_range(9) == 0);
        mtxt     = use_post ? "POST " : "GET ";
        for (int i = 0; i < mtxt.len(); i++)
            line.push_back(mtxt[i]);
        plen = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        for (int i = 0; i < plen; i++)
        begin
            sel = $urandom_range(19);
            if (i == 0 && $urandom_range(9) != 0)
                line.push_back(hrlp_pkg::CH_SLASH);
            else if (sel == 0)
                line.push_back(8'h00);
            else if (sel == 1)
                line.push_back(8'hFF);
            else
                line.push_back(8'($urandom_range(255)));
        end
        line.push_back(hrlp_pkg::CH_SPACE);
        for (int i = 0; i < vtxt.len(); i++)
            line.push_back(vtxt[i]);
        sel = $urandom_range(9);
        line.push_back(sel < 5 ? hrlp_pkg::CH_ONE
                               : (sel < 9 ? hrlp_pkg::CH_ZERO : 8'($urandom_range(255))));
        repeat ($urandom_range(2))
            line.push_back(8'($urandom_range(255)));
        // Corrupt one byte now and then
        if ($urandom_range(6) == 0)
            line[$urandom_range(line.size() - 1)] = 8'($urandom_range(255));
        // Cut the line short so the next first byte restarts mid-line
        if ($urandom_range(14) == 0)
        begin
            cut = $urandom_range(1, line.size() - 1);
            line = line[0:cut - 1];
        end
        foreach (line[i])
            send_byte(line[i], i == 0);
        // Stray bytes between lines
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase_start;
        int mode;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines with the reset register values
        send_byte(8'hFF, 1'b0);         // ignored: nothing started yet
        send_text("Q", 1'b1);           // method fails on its first byte
        send_text("POST  ", 1'b1);      // empty path with checking on
        send_text("POST /", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text(" HTTP/1.0Z", 1'b0);  // trailing byte is dropped

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                drain();
                set_config(!ph[0], !ph[1]);
            end
            mode = (ph + ph / 4) % 4;
            case (mode)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 88; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 88; end
                default: begin src_idle = 12; snk_stall = 12; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_request();
        end

        drain();
        $display("Sent %0d bytes over %0d phases, all four register settings, four flow patterns",
                 bytes_sent, NUM_PHASES);
        $display("Checked %0d path words; verdicts ok %0d, method %0d, path %0d, version %0d",
                 sb.path_words, sb.verdicts[hrlp_pkg::ST_OK],
                 sb.verdicts[hrlp_pkg::ST_BAD_METHOD],
                 sb.verdicts[hrlp_pkg::ST_BAD_PATH], sb.verdicts[hrlp_pkg::ST_BAD_VERSION]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
design/hrlp_pkg.sv
design/hrlp_decode.sv
design/hrlp_out_reg.sv
design/http_request_line_parser.sv
verif/http_request_line_parser_tb.sv
